// ===== design/srsw_pkg.sv =====
// Shared constants, codes and the result word type for the selective-repeat
// sender window. No dependencies; every other design file imports it.
package srsw_pkg;

   // window and chunk geometry
   localparam int WINDOW_SIZE = 4;
   localparam int CHUNK_BYTES = 8;

   // field widths
   localparam int CMD_W    = 2;
   localparam int OFFSET_W = 24;
   localparam int LEN_W    = 4;
   localparam int DATA_W   = 64;

   // window index and count widths
   localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

   // result queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // reciprocal for offset / CHUNK_BYTES, exact over every 24-bit offset
   localparam int DIV_SHIFT   = OFFSET_W + $clog2(CHUNK_BYTES);
   localparam int DIV_RECIP_W = DIV_SHIFT + 1;
   localparam int DIV_PROD_W  = OFFSET_W + DIV_RECIP_W;
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(
      ((64'd1 << DIV_SHIFT) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES));

   localparam logic [LEN_W-1:0] CHUNK_LEN  = LEN_W'(CHUNK_BYTES);
   localparam logic [CNT_W-1:0] WINDOW_CNT = CNT_W'(WINDOW_SIZE);

   // command codes
   typedef logic [CMD_W-1:0] command_type;
   localparam command_type CMD_SEND    = 2'd0;
   localparam command_type CMD_ACK     = 2'd1;
   localparam command_type CMD_TIMEOUT = 2'd2;

   // one emitted packet
   typedef struct packed {
      logic [OFFSET_W-1:0] packet_offset;
      logic [LEN_W-1:0]    packet_size;
      logic [DATA_W-1:0]   packet_payload;
      logic                final_packet;
      logic                odd_relay;
      logic                burst_end;
   } result_type;

endpackage

// ===== design/srsw_front.sv =====
// Front part: accepts commands, keeps the window state and entries, and
// pushes packet words into the result queue. Depends on srsw_pkg.
module srsw_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  srsw_pkg::command_type          req_command,
   input  logic [srsw_pkg::LEN_W-1:0]     req_chunk_length,
   input  logic [srsw_pkg::DATA_W-1:0]    req_chunk_bytes,
   input  logic [srsw_pkg::OFFSET_W-1:0]  req_ack_offset,
   input  logic                           csr_wr_en,
   input  logic [srsw_pkg::OFFSET_W-1:0]  csr_wr_data,
   output logic                           push,
   output srsw_pkg::result_type           push_data,
   input  logic                           q_full
);
   import srsw_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [OFFSET_W-1:0]      file_length_ff, file_length_in;
   logic [OFFSET_W-1:0]      next_offset_ff, next_offset_in;
   logic [CNT_W-1:0]         filled_ff, filled_in;
   logic [CNT_W-1:0]         acked_cnt_ff, acked_cnt_in;
   logic                     waiting_ff, waiting_in;
   logic [WINDOW_SIZE-1:0]   acked_ff, acked_in;
   logic [WINDOW_SIZE-1:0]   scan_mask_ff, scan_mask_in;

   logic [OFFSET_W-1:0]      ent_offset_ff  [WINDOW_SIZE];
   logic [LEN_W-1:0]         ent_size_ff    [WINDOW_SIZE];
   logic [DATA_W-1:0]        ent_payload_ff [WINDOW_SIZE];
   logic                     ent_final_ff   [WINDOW_SIZE];
   logic                     ent_odd_ff     [WINDOW_SIZE];

   logic                     accept;
   logic                     can_send;
   logic                     do_store;
   logic [IDX_W-1:0]         wr_idx;
   logic [LEN_W-1:0]         clen_sat;
   logic [DATA_W-1:0]        send_data;
   logic                     send_final;
   logic [DIV_PROD_W-1:0]    div_prod;
   logic                     send_odd;
   logic [WINDOW_SIZE-1:0]   filled_mask;
   logic [WINDOW_SIZE-1:0]   pending;
   logic [WINDOW_SIZE-1:0]   match_vec;
   logic [WINDOW_SIZE-1:0]   match_first;
   logic [WINDOW_SIZE-1:0]   scan_pick;
   logic [WINDOW_SIZE-1:0]   scan_rest;
   logic [IDX_W-1:0]         scan_idx;
   result_type               send_word;
   result_type               scan_word;

   assign busy   = (state_ff != ST_IDLE) || q_full;
   assign accept = start && !busy;

   // window occupancy and outstanding entries
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         filled_mask[i] = CNT_W'(i) < filled_ff;
         match_vec[i]   = filled_mask[i] && !acked_ff[i] &&
                          (ent_offset_ff[i] == req_ack_offset);
      end
   end
   assign pending     = filled_mask & ~acked_ff;
   assign match_first = match_vec & (~match_vec + WINDOW_SIZE'(1));

   // shape the chunk: saturate length, zero bytes past it
   assign clen_sat = (req_chunk_length > CHUNK_LEN) ? CHUNK_LEN : req_chunk_length;
   always_comb begin
      for (int b = 0; b < DATA_W / 8; b++) begin
         send_data[8*b +: 8] = (LEN_W'(b) < clen_sat) ? req_chunk_bytes[8*b +: 8] : 8'd0;
      end
   end

   // last-packet test and relay parity of offset / CHUNK_BYTES
   assign send_final = ({1'b0, next_offset_ff} + (OFFSET_W + 1)'(CHUNK_BYTES)) >=
                       {1'b0, file_length_ff};
   assign div_prod   = DIV_PROD_W'(next_offset_ff) * DIV_PROD_W'(DIV_RECIP);
   assign send_odd   = div_prod[DIV_SHIFT];

   assign can_send = !waiting_ff && (filled_ff < WINDOW_CNT);
   assign do_store = accept && (req_command == CMD_SEND) && can_send &&
                     (req_chunk_length != '0);
   assign wr_idx   = IDX_W'(filled_ff);

   always_comb begin
      send_word.packet_offset  = next_offset_ff;
      send_word.packet_size    = clen_sat;
      send_word.packet_payload = send_data;
      send_word.final_packet   = send_final;
      send_word.odd_relay      = send_odd;
      send_word.burst_end      = 1'b1;
   end

   // resend scan: lowest outstanding entry first
   assign scan_pick = scan_mask_ff & (~scan_mask_ff + WINDOW_SIZE'(1));
   assign scan_rest = scan_mask_ff & ~scan_pick;
   always_comb begin
      scan_idx = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         if (scan_pick[i]) begin
            scan_idx = scan_idx | IDX_W'(i);
         end
      end
   end
   always_comb begin
      scan_word.packet_offset  = ent_offset_ff[scan_idx];
      scan_word.packet_size    = ent_size_ff[scan_idx];
      scan_word.packet_payload = ent_payload_ff[scan_idx];
      scan_word.final_packet   = ent_final_ff[scan_idx];
      scan_word.odd_relay      = ent_odd_ff[scan_idx];
      scan_word.burst_end      = (scan_rest == '0);
   end

   // push either a fresh packet or a resend
   always_comb begin
      if (state_ff == ST_SCAN) begin
         push      = !q_full;
         push_data = scan_word;
      end else begin
         push      = do_store;
         push_data = send_word;
      end
   end

   // next window state
   always_comb begin
      state_in       = state_ff;
      file_length_in = csr_wr_en ? csr_wr_data : file_length_ff;
      next_offset_in = next_offset_ff;
      filled_in      = filled_ff;
      acked_cnt_in   = acked_cnt_ff;
      waiting_in     = waiting_ff;
      acked_in       = acked_ff;
      scan_mask_in   = scan_mask_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_SEND: begin
                     if (can_send) begin
                        if (req_chunk_length == '0) begin
                           if (filled_ff != '0) begin
                              waiting_in = 1'b1;
                           end
                        end else begin
                           acked_in[wr_idx] = 1'b0;
                           filled_in        = filled_ff + CNT_W'(1);
                           next_offset_in   = next_offset_ff + OFFSET_W'(clen_sat);
                           if (filled_in >= WINDOW_CNT || send_final) begin
                              waiting_in = 1'b1;
                           end
                        end
                     end
                  end
                  CMD_ACK: begin
                     acked_in = acked_ff | match_first;
                     if (match_vec != '0) begin
                        acked_cnt_in = acked_cnt_ff + CNT_W'(1);
                     end
                     // reopen once every sent packet is acknowledged
                     if (waiting_ff && acked_cnt_in >= filled_ff) begin
                        filled_in    = '0;
                        acked_cnt_in = '0;
                        waiting_in   = 1'b0;
                        acked_in     = '0;
                     end
                  end
                  CMD_TIMEOUT: begin
                     scan_mask_in = pending;
                     if (pending != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!q_full) begin
               scan_mask_in = scan_rest;
               if (scan_rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         file_length_ff <= '0;
         next_offset_ff <= '0;
         filled_ff      <= '0;
         acked_cnt_ff   <= '0;
         waiting_ff     <= 1'b0;
         acked_ff       <= '0;
         scan_mask_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         file_length_ff <= file_length_in;
         next_offset_ff <= next_offset_in;
         filled_ff      <= filled_in;
         acked_cnt_ff   <= acked_cnt_in;
         waiting_ff     <= waiting_in;
         acked_ff       <= acked_in;
         scan_mask_ff   <= scan_mask_in;
      end
   end

   // store the new packet in its window entry
   always_ff @(posedge clock) begin
      if (do_store) begin
         ent_offset_ff[wr_idx]  <= next_offset_ff;
         ent_size_ff[wr_idx]    <= clen_sat;
         ent_payload_ff[wr_idx] <= send_data;
         ent_final_ff[wr_idx]   <= send_final;
         ent_odd_ff[wr_idx]     <= send_odd;
      end
   end

endmodule

// ===== design/srsw_queue.sv =====
// Short FIFO of packet words between the front and the back part.
// Depends on srsw_pkg.
module srsw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  srsw_pkg::result_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output srsw_pkg::result_type  head,
   output logic                  empty
);
   import srsw_pkg::*;

   result_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/srsw_emit.sv =====
// Back part: drains the result queue one word a cycle into the registered
// result ports with a one-cycle strobe. Depends on srsw_pkg.
module srsw_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  srsw_pkg::result_type  q_head,
   output logic                  pop,
   output logic                  rsp_valid,
   output srsw_pkg::result_type  rsp_word
);
   import srsw_pkg::*;

   logic        valid_ff;
   result_type  word_ff;

   // the receiver always takes the word, so pop whenever one waits
   assign pop = !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pop;
      end
   end

   // hold the payload of the word on the ports
   always_ff @(posedge clock) begin
      if (pop) begin
         word_ff <= q_head;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== design/selective_repeat_sender_window.sv =====
// Selective-repeat sender window: top level tying front, result queue and
// back part together. Depends on srsw_pkg, srsw_front, srsw_queue, srsw_emit.
//
// Usage:
//   Command channel: a command is taken at a clock edge with start high and
//   busy low. Send (0) stamps a nonzero-length chunk with its offset and
//   emits it if the window is open; ack (1) marks the matching window entry;
//   timeout (2) resends every window entry that is not yet acknowledged.
//   Result channel: each packet appears for one cycle with rsp_valid high;
//   rsp_burst_end marks the last packet a command causes. The receiver
//   always takes the packet, there is no back-pressure.
//   Config: csr_wr_data is written to the file length at an edge with
//   csr_wr_en high; write it only while the block is quiet.
//   Timing: a send's packet passes the queue slot and the registered result
//   port before it shows. A timeout holds busy while the front part's resend
//   scan pushes one entry per cycle, holding while the queue is full (up to
//   WINDOW_SIZE entries, four here); the first resend passes the ST_SCAN
//   state register, the queue slot and the result port register.
//   Reset: synchronous, clears the window, offsets, file length and queue.
module selective_repeat_sender_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [srsw_pkg::CMD_W-1:0]     req_command,
   input  logic [srsw_pkg::LEN_W-1:0]     req_chunk_length,
   input  logic [srsw_pkg::DATA_W-1:0]    req_chunk_bytes,
   input  logic [srsw_pkg::OFFSET_W-1:0]  req_ack_offset,
   input  logic                           csr_wr_en,
   input  logic [srsw_pkg::OFFSET_W-1:0]  csr_wr_data,
   output logic                           rsp_valid,
   output logic [srsw_pkg::OFFSET_W-1:0]  rsp_packet_offset,
   output logic [srsw_pkg::LEN_W-1:0]     rsp_packet_size,
   output logic [srsw_pkg::DATA_W-1:0]    rsp_packet_payload,
   output logic                           rsp_final_packet,
   output logic                           rsp_odd_relay,
   output logic                           rsp_burst_end
);
   import srsw_pkg::*;

   logic        push;
   result_type  push_data;
   logic        q_full;
   logic        q_empty;
   logic        pop;
   result_type  q_head;
   result_type  rsp_word;

   // command intake and window state
   srsw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_chunk_length (req_chunk_length),
      .req_chunk_bytes  (req_chunk_bytes),
      .req_ack_offset   (req_ack_offset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .push             (push),
      .push_data        (push_data),
      .q_full           (q_full)
   );

   // decouple front and back
   srsw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // result port driver
   srsw_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_packet_offset  = rsp_word.packet_offset;
   assign rsp_packet_size    = rsp_word.packet_size;
   assign rsp_packet_payload = rsp_word.packet_payload;
   assign rsp_final_packet   = rsp_word.final_packet;
   assign rsp_odd_relay      = rsp_word.odd_relay;
   assign rsp_burst_end      = rsp_word.burst_end;

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full))
      else $error("packet word pushed into full queue");

   // a strobe always follows a word waiting in the queue
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(!q_empty))
      else $error("result strobe without a queued word");

   // reset leaves the block quiet and ready
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("block not quiet after reset");

endmodule
